// ===== hdl/kct_pkg.sv =====
// Shared types, codes and defaults for the keyed count table.
package kct_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_KEY_BITS    = 16;

    localparam int REQ_KEY_BITS = 16;
    localparam int AMOUNT_BITS  = 32;
    localparam int COUNT_BITS   = 31;
    localparam int STATUS_BITS  = 2;

    localparam int S_TDATA_BITS = 56;   // 2 + 16 + 32 = 50, padded to bytes
    localparam int M_TDATA_BITS = 40;   // 31 + 1 + 2 = 34, padded to bytes

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SET    = 2'd2,
        OP_QUERY  = 2'd3
    } kct_op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_DONE    = 2'd0,
        STATUS_IGNORED = 2'd1,
        STATUS_FULL    = 2'd2,
        STATUS_SAT     = 2'd3
    } kct_status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_EXEC
    } kct_state_t;

    typedef struct packed {
        kct_op_t                 opcode;
        logic [REQ_KEY_BITS-1:0] key;
        logic [AMOUNT_BITS-1:0]  amount;
    } kct_req_t;

    typedef struct packed {
        kct_status_t            status;
        logic                   present;
        logic [COUNT_BITS-1:0]  count_after;
    } kct_result_t;

endpackage

// ===== hdl/kct_mem.sv =====
// Entry store: one write port, one read port with registered read data.
module kct_mem #(
    parameter int ADDR_BITS = 6,
    parameter int DATA_BITS = 48
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem_reg [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/kct_engine.sv =====
// Request sequencer: clearing pass, lookup scan, update and write-back.
module kct_engine #(
    parameter int TABLE_DEPTH = kct_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_BITS    = kct_pkg::DEF_KEY_BITS,
    parameter int ADDR_BITS   = $clog2(TABLE_DEPTH),
    parameter int DATA_BITS   = 1 + KEY_BITS + kct_pkg::COUNT_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  kct_pkg::kct_req_t     req,
    output logic                  res_valid,
    input  logic                  res_ready,
    output kct_pkg::kct_result_t  res,
    output logic                  wr_en,
    output logic [ADDR_BITS-1:0]  wr_addr,
    output logic [DATA_BITS-1:0]  wr_data,
    output logic                  rd_en,
    output logic [ADDR_BITS-1:0]  rd_addr,
    input  logic [DATA_BITS-1:0]  rd_data
);

    import kct_pkg::*;

    localparam logic [ADDR_BITS:0] DEPTH_W = (ADDR_BITS+1)'(TABLE_DEPTH);
    localparam logic [ADDR_BITS:0] LAST_W  = (ADDR_BITS+1)'(TABLE_DEPTH - 1);

    kct_state_t state_reg, state_next;
    logic [ADDR_BITS:0]   addr_reg, addr_next;
    logic                 pend_reg, pend_next;
    logic [ADDR_BITS-1:0] pend_addr_reg, pend_addr_next;
    logic                 hit_reg, hit_next;
    logic                 free_reg, free_next;
    logic [ADDR_BITS-1:0] hit_idx_reg, hit_idx_next;
    logic [ADDR_BITS-1:0] free_idx_reg, free_idx_next;
    logic [COUNT_BITS-1:0] hit_count_reg, hit_count_next;
    kct_op_t              op_reg, op_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [AMOUNT_BITS-1:0] amount_reg, amount_next;

    logic [31:0]          key_wide;
    logic [KEY_BITS-1:0]  key_in;
    logic                 rd_valid;
    logic [KEY_BITS-1:0]  rd_key;
    logic [COUNT_BITS-1:0] rd_count;
    logic [COUNT_BITS-1:0] mag;
    logic                 positive;
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS:0]  sum;
    logic [COUNT_BITS-1:0] diff;
    logic                 key_zero;
    logic                 ex_wr;
    logic [ADDR_BITS-1:0] ex_addr;
    logic                 ex_valid;
    logic [COUNT_BITS-1:0] ex_count;
    logic [COUNT_BITS-1:0] r_count;
    kct_status_t          r_status;

    assign key_wide = {{(32-REQ_KEY_BITS){1'b0}}, req.key};
    assign key_in   = key_wide[KEY_BITS-1:0];

    assign rd_valid = rd_data[DATA_BITS-1];
    assign rd_key   = rd_data[KEY_BITS+COUNT_BITS-1:COUNT_BITS];
    assign rd_count = rd_data[COUNT_BITS-1:0];

    // update datapath for the request held in the registers
    assign mag      = amount_reg[COUNT_BITS-1:0];
    assign positive = !amount_reg[AMOUNT_BITS-1] && (mag != '0);
    assign cur      = hit_reg ? hit_count_reg : '0;
    assign sum      = {1'b0, cur} + {1'b0, mag};
    assign diff     = cur - mag;
    assign key_zero = (key_reg == '0);

    always_comb begin
        ex_wr    = 1'b0;
        ex_addr  = hit_idx_reg;
        ex_valid = 1'b1;
        ex_count = mag;
        r_count  = cur;
        r_status = STATUS_DONE;
        if (key_zero) begin
            r_count  = '0;
            r_status = STATUS_IGNORED;
        end else begin
            unique case (op_reg)
                OP_ADD: begin
                    if (!positive) begin
                        r_status = STATUS_IGNORED;
                    end else if (hit_reg) begin
                        ex_wr = 1'b1;
                        if (sum[COUNT_BITS]) begin
                            ex_count = COUNT_MAX;
                            r_status = STATUS_SAT;
                        end else begin
                            ex_count = sum[COUNT_BITS-1:0];
                        end
                        r_count = ex_count;
                    end else if (free_reg) begin
                        ex_wr   = 1'b1;
                        ex_addr = free_idx_reg;
                        r_count = mag;
                    end else begin
                        r_count  = '0;
                        r_status = STATUS_FULL;
                    end
                end
                OP_REMOVE: begin
                    if (!positive) begin
                        r_status = STATUS_IGNORED;
                    end else if (!hit_reg) begin
                        r_count = '0;
                    end else if (cur <= mag) begin
                        ex_wr    = 1'b1;
                        ex_valid = 1'b0;
                        r_count  = '0;
                    end else begin
                        ex_wr    = 1'b1;
                        ex_count = diff;
                        r_count  = diff;
                    end
                end
                OP_SET: begin
                    if (!positive) begin
                        ex_wr    = hit_reg;
                        ex_valid = 1'b0;
                        r_count  = '0;
                    end else if (hit_reg) begin
                        ex_wr   = 1'b1;
                        r_count = mag;
                    end else if (free_reg) begin
                        ex_wr   = 1'b1;
                        ex_addr = free_idx_reg;
                        r_count = mag;
                    end else begin
                        r_count  = '0;
                        r_status = STATUS_FULL;
                    end
                end
                OP_QUERY: begin
                    r_count = cur;
                end
            endcase
        end
    end

    always_comb begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        pend_next      = 1'b0;
        pend_addr_next = addr_reg[ADDR_BITS-1:0];
        hit_next       = hit_reg;
        free_next      = free_reg;
        hit_idx_next   = hit_idx_reg;
        free_idx_next  = free_idx_reg;
        hit_count_next = hit_count_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        amount_next    = amount_reg;
        req_ready      = 1'b0;
        res_valid      = 1'b0;
        res            = '{status: r_status, present: (r_count != '0), count_after: r_count};
        wr_en          = 1'b0;
        wr_addr        = ex_addr;
        wr_data        = {ex_valid, key_reg, ex_count};
        rd_en          = 1'b0;
        rd_addr        = addr_reg[ADDR_BITS-1:0];

        unique case (state_reg)
            S_CLEAR: begin
                wr_en     = 1'b1;
                wr_addr   = addr_reg[ADDR_BITS-1:0];
                wr_data   = '0;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_W) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    op_next     = req.opcode;
                    key_next    = key_in;
                    amount_next = req.amount;
                    addr_next   = '0;
                    hit_next    = 1'b0;
                    free_next   = 1'b0;
                    state_next  = (key_in == '0) ? S_EXEC : S_SCAN;
                end
            end
            S_SCAN: begin
                rd_en = (addr_reg < DEPTH_W);
                if (rd_en) begin
                    addr_next = addr_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    if (rd_valid && (rd_key == key_reg) && !hit_reg) begin
                        hit_next       = 1'b1;
                        hit_idx_next   = pend_addr_reg;
                        hit_count_next = rd_count;
                    end
                    if (!rd_valid && !free_reg) begin
                        free_next     = 1'b1;
                        free_idx_next = pend_addr_reg;
                    end
                end
                if (!rd_en && !pend_reg) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    wr_en      = ex_wr;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            addr_reg  <= '0;
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            pend_reg  <= pend_next;
            hit_reg   <= hit_next;
            free_reg  <= free_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg <= pend_addr_next;
        hit_idx_reg   <= hit_idx_next;
        free_idx_reg  <= free_idx_next;
        hit_count_reg <= hit_count_next;
        op_reg        <= op_next;
        key_reg       <= key_next;
        amount_reg    <= amount_next;
    end

endmodule

// ===== hdl/keyed_count_table.sv =====
// Keyed count table top level: stream ports, entry store, sequencer, output register.
//
// A bounded table of key/count pairs held in one synchronous memory of
// TABLE_DEPTH entries (valid, key, 31-bit count). Each request (add,
// remove, set, query) is handled one at a time: the sequencer reads every
// entry once through the single read port to find the key and the lowest
// free entry, works out the new count, and writes the entry back in the
// cycle its result is handed to the output register. The lookup scan reads
// one entry per cycle; a request with key 0 skips the scan and is answered
// directly. The output register lets the next request be accepted while a
// result still waits for m_tready. After reset a clearing pass marks every
// entry free, one per cycle; s_tready stays low until it is done. Keys
// wider than the 16-bit field are zero-extended; narrower keys use the low
// KEY_BITS bits.
module keyed_count_table #(
    parameter int TABLE_DEPTH = kct_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_BITS    = kct_pkg::DEF_KEY_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // opcode [1:0], key [17:2], amount [49:18], zero pad [55:50]
    input  logic [kct_pkg::S_TDATA_BITS-1:0]  s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // count_after [30:0], present [31], status [33:32], zero pad [39:34]
    output logic [kct_pkg::M_TDATA_BITS-1:0]  m_tdata
);

    import kct_pkg::*;

    localparam int ADDR_BITS = $clog2(TABLE_DEPTH);
    localparam int DATA_BITS = 1 + KEY_BITS + COUNT_BITS;
    localparam int RES_BITS  = COUNT_BITS + 1 + STATUS_BITS;

    kct_req_t    req;
    kct_result_t res;
    logic        res_valid;
    logic        res_ready;

    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [DATA_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
    logic [DATA_BITS-1:0] rd_data;

    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_BITS-1:0] m_tdata_reg;

    // unpack the request word
    assign req.opcode = kct_op_t'(s_tdata[1:0]);
    assign req.key    = s_tdata[REQ_KEY_BITS+1:2];
    assign req.amount = s_tdata[REQ_KEY_BITS+AMOUNT_BITS+1:REQ_KEY_BITS+2];

    kct_mem #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    kct_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .ADDR_BITS   (ADDR_BITS),
        .DATA_BITS   (DATA_BITS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // output register: loads when empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= {{(M_TDATA_BITS-RES_BITS){1'b0}}, res};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hdl/kct_checker.sv =====
// Port-level checks for the keyed count table, bound to the top level.
module kct_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [kct_pkg::M_TDATA_BITS-1:0]  m_tdata
);

    import kct_pkg::*;

    // no result survives a reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // presence flag agrees with the count
    a_present: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[COUNT_BITS] == (m_tdata[COUNT_BITS-1:0] != '0)))
        else $error("present flag disagrees with count");

    // a dropped insert reports no count
    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[COUNT_BITS+2:COUNT_BITS+1] == STATUS_FULL)
        |-> (m_tdata[COUNT_BITS-1:0] == '0))
        else $error("full status with non-zero count");

    // one request at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

endmodule

bind keyed_count_table kct_checker u_kct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
